// ===== rtl/slotted_message_fifo_top_macros.svh =====
// Assertion macros used by the checker file.
`ifndef SLOTTED_MESSAGE_FIFO_TOP_MACROS_SVH
`define SLOTTED_MESSAGE_FIFO_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/smf_pkg.sv =====
package smf_pkg;

	localparam int SLOTS      = 16;
	localparam int SLOT_BYTES = 32;

	localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int ADDR_W  = (SLOTS * SLOT_BYTES > 1) ? $clog2(SLOTS * SLOT_BYTES) : 1;

	localparam int REQ_W       = 2;
	localparam int BYTE_W      = 8;
	localparam int CAP_W       = 8;
	localparam int STATUS_W    = 3;
	localparam int LEN_W       = 6;
	localparam int OCC_W       = 4;
	localparam int TOTAL_W     = 32;
	localparam int MAX_SIZE_W  = 6;
	localparam int MAX_COUNT_W = 4;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 6;
	localparam int CMP_W       = (CNT_W > MAX_COUNT_W) ? CNT_W : MAX_COUNT_W;

	localparam logic [REQ_W-1:0] REQ_ENQ   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DEQ   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_STATS = 2'd2;

	localparam logic [STATUS_W-1:0] ST_ENQUEUED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DATA     = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT = 1'd1;

	localparam logic [MAX_SIZE_W-1:0]  MAX_SIZE_RST  = 6'd32;
	localparam logic [MAX_COUNT_W-1:0] MAX_COUNT_RST = 4'd15;

	typedef struct packed {
		logic accept;
		logic stream_start;
		logic issue;
	} ctrl_cmd_t;

	typedef struct packed {
		logic deq_ok;
		logic issue_last;
	} dp_stat_t;

endpackage

// ===== rtl/slotted_message_fifo_top.sv =====
// Channel    Handshake                    Payload
// input      start, transfer when !busy   req_type, data_byte, msg_last, read_capacity
// result     result_valid, one cycle      status, out_byte, last, length, occupancy,
//                                         peak_occupancy, enq_count, drop_count, deq_count
// config     cfg_we, no wait              cfg_index, cfg_data
//
// Enqueue, statistics reset, empty and bad-request items do not raise busy; a result,
// if any, appears in the cycle after the transfer.
// A dequeue of n bytes holds busy while the slot memory is read at one byte per cycle
// through its registered read port; each byte appears in the cycle after its read,
// and the next item can be taken once busy falls.
// Reset is asynchronous; it empties the ring, clears the counters and restores the
// register defaults.
// The receiver cannot stall; every result is valid for exactly one cycle.
module slotted_message_fifo_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [smf_pkg::REQ_W-1:0]       req_type,
	input  logic [smf_pkg::BYTE_W-1:0]      data_byte,
	input  logic                            msg_last,
	input  logic [smf_pkg::CAP_W-1:0]       read_capacity,
	input  logic                            cfg_we,
	input  logic [smf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [smf_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                            result_valid,
	output logic [smf_pkg::STATUS_W-1:0]    status,
	output logic [smf_pkg::BYTE_W-1:0]      out_byte,
	output logic                            last,
	output logic [smf_pkg::LEN_W-1:0]       length,
	output logic [smf_pkg::OCC_W-1:0]       occupancy,
	output logic [smf_pkg::OCC_W-1:0]       peak_occupancy,
	output logic [smf_pkg::TOTAL_W-1:0]     enq_count,
	output logic [smf_pkg::TOTAL_W-1:0]     drop_count,
	output logic [smf_pkg::TOTAL_W-1:0]     deq_count
);
	import smf_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	smf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	smf_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.req_type       (req_type),
		.data_byte      (data_byte),
		.msg_last       (msg_last),
		.read_capacity  (read_capacity),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.result_valid   (result_valid),
		.status         (status),
		.out_byte       (out_byte),
		.last           (last),
		.length         (length),
		.occupancy      (occupancy),
		.peak_occupancy (peak_occupancy),
		.enq_count      (enq_count),
		.drop_count     (drop_count),
		.deq_count      (deq_count)
	);

endmodule

// ===== rtl/smf_ctrl.sv =====
module smf_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [smf_pkg::REQ_W-1:0] req_type,
	input  smf_pkg::dp_stat_t         stat,
	output smf_pkg::ctrl_cmd_t        cmd,
	output logic                      busy
);
	import smf_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE   = 2'b01,
		S_STREAM = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd.accept       = start && (state_q == S_IDLE);
		cmd.stream_start = cmd.accept && (req_type == REQ_DEQ) && stat.deq_ok;
		cmd.issue        = (state_q == S_STREAM);
		busy             = (state_q == S_STREAM);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.stream_start) begin
					state_d = S_STREAM;
				end
			end
			S_STREAM: begin
				if (stat.issue_last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/smf_datapath.sv =====
module smf_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  smf_pkg::ctrl_cmd_t              cmd,
	output smf_pkg::dp_stat_t               stat,
	input  logic [smf_pkg::REQ_W-1:0]       req_type,
	input  logic [smf_pkg::BYTE_W-1:0]      data_byte,
	input  logic                            msg_last,
	input  logic [smf_pkg::CAP_W-1:0]       read_capacity,
	input  logic                            cfg_we,
	input  logic [smf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [smf_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                            result_valid,
	output logic [smf_pkg::STATUS_W-1:0]    status,
	output logic [smf_pkg::BYTE_W-1:0]      out_byte,
	output logic                            last,
	output logic [smf_pkg::LEN_W-1:0]       length,
	output logic [smf_pkg::OCC_W-1:0]       occupancy,
	output logic [smf_pkg::OCC_W-1:0]       peak_occupancy,
	output logic [smf_pkg::TOTAL_W-1:0]     enq_count,
	output logic [smf_pkg::TOTAL_W-1:0]     drop_count,
	output logic [smf_pkg::TOTAL_W-1:0]     deq_count
);
	import smf_pkg::*;

	logic [BYTE_W-1:0]      mem [SLOTS*SLOT_BYTES];
	logic [LEN_W-1:0]       slot_len [SLOTS];

	logic [MAX_SIZE_W-1:0]  max_size_q;
	logic [MAX_COUNT_W-1:0] max_count_q;
	logic [SLOT_W-1:0]      head_q;
	logic [SLOT_W-1:0]      tail_q;
	logic [CNT_W-1:0]       fill_q;
	logic [CNT_W-1:0]       peak_q;
	logic [LEN_W-1:0]       wo_q;
	logic                   dropping_q;
	logic [TOTAL_W-1:0]     enq_q;
	logic [TOTAL_W-1:0]     drop_q;
	logic [TOTAL_W-1:0]     deq_q;

	logic [ADDR_W-1:0]      base_q;
	logic [LEN_W-1:0]       rd_idx_q;
	logic [LEN_W-1:0]       n_q;
	logic [BYTE_W-1:0]      rdata_q;

	logic                   res_valid_q;
	logic [STATUS_W-1:0]    res_status_q;
	logic [LEN_W-1:0]       res_len_q;
	logic                   res_last_q;
	logic                   res_mem_q;

	logic                   enq_acc;
	logic                   deq_acc;
	logic                   stats_acc;
	logic [LEN_W-1:0]       eff_size;
	logic                   ring_full;
	logic                   drop_now;
	logic                   store;
	logic [LEN_W-1:0]       wo_next;
	logic [CNT_W-1:0]       fill_inc;
	logic [SLOT_W-1:0]      tail_inc;
	logic [SLOT_W-1:0]      head_inc;
	logic [LEN_W-1:0]       head_len;
	logic [LEN_W-1:0]       deq_n;
	logic [ADDR_W-1:0]      waddr;
	logic [ADDR_W-1:0]      raddr;

	always_comb begin
		enq_acc   = cmd.accept && (req_type == REQ_ENQ);
		deq_acc   = cmd.accept && (req_type == REQ_DEQ);
		stats_acc = cmd.accept && (req_type == REQ_STATS);

		if (max_size_q == '0) begin
			eff_size = LEN_W'(1);
		end else if (max_size_q > LEN_W'(SLOT_BYTES)) begin
			eff_size = LEN_W'(SLOT_BYTES);
		end else begin
			eff_size = max_size_q;
		end

		ring_full = (CMP_W'(fill_q) >= CMP_W'(max_count_q)) || (fill_q == CNT_W'(SLOTS));
		drop_now  = dropping_q || ((wo_q == '0) && ring_full);
		store     = enq_acc && !drop_now && (wo_q < eff_size);
		wo_next   = store ? wo_q + LEN_W'(1) : wo_q;
		fill_inc  = fill_q + CNT_W'(1);
		tail_inc  = (tail_q == SLOT_W'(SLOTS - 1)) ? '0 : tail_q + SLOT_W'(1);
		head_inc  = (head_q == SLOT_W'(SLOTS - 1)) ? '0 : head_q + SLOT_W'(1);
		head_len  = slot_len[head_q];

		if ({{(CAP_W-LEN_W){1'b0}}, head_len} <= read_capacity) begin
			deq_n = head_len;
		end else begin
			deq_n = read_capacity[LEN_W-1:0];
		end

		waddr = ADDR_W'(tail_q) * ADDR_W'(SLOT_BYTES) + ADDR_W'(wo_q);
		raddr = base_q + ADDR_W'(rd_idx_q);

		stat.deq_ok     = (read_capacity != '0) && (fill_q != '0);
		stat.issue_last = (rd_idx_q == n_q - LEN_W'(1));
	end

	always_ff @(posedge clk) begin
		if (store) begin
			mem[waddr] <= data_byte;
		end
		if (cmd.issue) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (enq_acc && msg_last && !drop_now) begin
			slot_len[tail_q] <= wo_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q  <= MAX_SIZE_RST;
			max_count_q <= MAX_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_SIZE:  max_size_q  <= cfg_data[MAX_SIZE_W-1:0];
				CFG_MAX_COUNT: max_count_q <= cfg_data[MAX_COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			fill_q     <= '0;
			peak_q     <= '0;
			wo_q       <= '0;
			dropping_q <= 1'b0;
			enq_q      <= '0;
			drop_q     <= '0;
			deq_q      <= '0;
		end else begin
			if (enq_acc) begin
				if (!msg_last) begin
					dropping_q <= drop_now;
					wo_q       <= wo_next;
				end else if (drop_now) begin
					dropping_q <= 1'b0;
					wo_q       <= '0;
					drop_q     <= drop_q + TOTAL_W'(1);
				end else begin
					wo_q   <= '0;
					tail_q <= tail_inc;
					fill_q <= fill_inc;
					enq_q  <= enq_q + TOTAL_W'(1);
					if (fill_inc > peak_q) begin
						peak_q <= fill_inc;
					end
				end
			end
			if (cmd.stream_start) begin
				head_q <= head_inc;
				fill_q <= fill_q - CNT_W'(1);
				deq_q  <= deq_q + TOTAL_W'(1);
			end
			if (stats_acc) begin
				enq_q  <= '0;
				drop_q <= '0;
				deq_q  <= '0;
				peak_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			rd_idx_q <= '0;
			n_q      <= '0;
		end else if (cmd.stream_start) begin
			base_q   <= ADDR_W'(head_q) * ADDR_W'(SLOT_BYTES);
			rd_idx_q <= '0;
			n_q      <= deq_n;
		end else if (cmd.issue) begin
			rd_idx_q <= rd_idx_q + LEN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			res_status_q <= ST_ENQUEUED;
			res_len_q    <= '0;
			res_last_q   <= 1'b0;
			res_mem_q    <= 1'b0;
		end else if (cmd.issue) begin
			res_valid_q  <= 1'b1;
			res_status_q <= ST_DATA;
			res_len_q    <= n_q;
			res_last_q   <= stat.issue_last;
			res_mem_q    <= 1'b1;
		end else if (enq_acc && msg_last) begin
			res_valid_q  <= 1'b1;
			res_status_q <= drop_now ? ST_DROPPED : ST_ENQUEUED;
			res_len_q    <= drop_now ? '0 : wo_next;
			res_last_q   <= 1'b1;
			res_mem_q    <= 1'b0;
		end else if (deq_acc && !stat.deq_ok) begin
			res_valid_q  <= 1'b1;
			res_status_q <= (read_capacity == '0) ? ST_BAD : ST_EMPTY;
			res_len_q    <= '0;
			res_last_q   <= 1'b1;
			res_mem_q    <= 1'b0;
		end else begin
			res_valid_q  <= 1'b0;
			res_len_q    <= '0;
			res_last_q   <= 1'b1;
			res_mem_q    <= 1'b0;
		end
	end

	always_comb begin
		result_valid   = res_valid_q;
		status         = res_status_q;
		out_byte       = res_mem_q ? rdata_q : '0;
		last           = res_last_q;
		length         = res_len_q;
		occupancy      = fill_q[OCC_W-1:0];
		peak_occupancy = peak_q[OCC_W-1:0];
		enq_count      = enq_q;
		drop_count     = drop_q;
		deq_count      = deq_q;
	end

endmodule

// ===== rtl/smf_checker.sv =====
`include "slotted_message_fifo_top_macros.svh"

module smf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic [smf_pkg::REQ_W-1:0]       req_type,
	input logic [smf_pkg::CAP_W-1:0]       read_capacity,
	input logic                            msg_last,
	input logic                            result_valid,
	input logic [smf_pkg::STATUS_W-1:0]    status,
	input logic                            last,
	input logic [smf_pkg::LEN_W-1:0]       length
);
	import smf_pkg::*;

	`SMF_ASSERT_NEXT(a_bad_request, clk, arst_n, start && !busy && req_type == REQ_DEQ && read_capacity == '0, result_valid && status == ST_BAD && last, "Zero capacity dequeue did not give a bad-request result.")

	`SMF_ASSERT_NEXT(a_stream_gapless, clk, arst_n, result_valid && status == ST_DATA && !last, result_valid && status == ST_DATA, "Dequeue byte stream has a gap.")

	`SMF_ASSERT_NEXT(a_no_spurious, clk, arst_n, start && !busy && req_type == REQ_ENQ && !msg_last, !result_valid, "Non-final enqueue byte produced a result.")

	`SMF_ASSERT_IMP(a_single_last, clk, arst_n, result_valid && status != ST_DATA, last, "Status result is not marked last.")

	`SMF_ASSERT_IMP(a_data_length, clk, arst_n, result_valid && status == ST_DATA, length != '0, "Data byte result has zero length.")

endmodule

bind slotted_message_fifo_top smf_checker u_smf_checker (.*);
